/* design/kss_pkg.sv */
package kss_pkg;

	localparam int DEF_SLOT_COUNT = 16;

	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int CONF_W  = 32;
	localparam int TIME_W  = 32;
	localparam int COUNT_W = 32;
	localparam int OP_W    = 2;
	localparam int SLOT_FIELD_W   = 4;
	localparam int ACTIVE_FIELD_W = 5;

	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 208;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_DONE
	} state_t;

	// One slot of the table as held in the memory.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
		logic [CONF_W-1:0] conf;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	// Outcome flags of one scan over the table.
	typedef struct packed {
		logic hit;
		logic free;
	} scan_flags_t;

endpackage

/* design/keyed_slot_store_with_eviction_unit.sv */
// Keyed slot store with lowest-priority eviction.
//
// Requests arrive as beats on the s_ channel: s_tuser carries the operation
// (write, read or clear) and s_tdata carries key, value, confidence and
// timestep. Every request produces exactly one result beat on the m_ channel
// with status, read data, slot index, eviction flag, occupancy and the four
// running counters.
//
// The table lives in a memory with one read and one write port, read one slot per
// cycle while a shared compare unit tracks the key match, the lowest free slot and
// the eviction victim. A write or read scans every slot before its result beat goes
// out: the reads, the last compare, the table and counter update, and the result
// load. A clear or an unused operation code skips the scan and goes straight to the
// update. s_tready is high only while the sequencer is idle, so a new request is
// taken only once the previous one has loaded its result beat.
//
// Reset invalidates every slot and zeroes occupancy and counters; unwritten slot
// contents are never used, so no clearing pass runs. A stalled receiver holds the
// result beat in the output register; the next request is still taken and processed,
// and its result waits until the pending beat has been taken.
module keyed_slot_store_with_eviction_unit #(
	parameter int SLOT_COUNT = kss_pkg::DEF_SLOT_COUNT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0: key[31:0], value[63:32], confidence[95:64],
	// timestep[127:96].
	input  logic [kss_pkg::IN_TDATA_W-1:0]  s_tdata,
	// Fields from bit 0: operation[1:0].
	input  logic [kss_pkg::OP_W-1:0]        s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// Fields from bit 0: status[0], read_value[32:1], read_confidence[64:33],
	// slot_index[68:65], evicted[69], active_count[74:70],
	// write_count[106:75], hit_count[138:107], miss_count[170:139],
	// eviction_count[202:171], zero padding[207:203].
	output logic [kss_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import kss_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int OCC_W = $clog2(SLOT_COUNT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	state_t state_q, state_d;

	// Request captured at acceptance.
	logic [OP_W-1:0]   op_q;
	entry_t            req_q;

	// Table storage: payload in a memory, valid bits in flip-flops.
	entry_t            mem [SLOT_COUNT];
	entry_t            rd_s1;
	logic [SLOT_COUNT-1:0] valid_q;
	logic              vbit_s1;
	logic              step_s1;
	logic [IDX_W-1:0]  idx_s1;

	// Read address counter for the scan.
	logic [IDX_W-1:0]  addr_q;
	logic              issue_q;

	// Occupancy and counters.
	logic [OCC_W-1:0]   occ_q;
	logic [COUNT_W-1:0] writes_q;
	logic [COUNT_W-1:0] hits_q;
	logic [COUNT_W-1:0] misses_q;
	logic [COUNT_W-1:0] evicts_q;

	// Per-request result fields, settled in the update cycle.
	logic              res_status_q;
	logic [DATA_W-1:0] res_value_q;
	logic [CONF_W-1:0] res_conf_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              res_evict_q;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// Scan results.
	scan_flags_t       flags;
	logic [IDX_W-1:0]  hit_idx;
	logic [DATA_W-1:0] hit_value;
	logic [CONF_W-1:0] hit_conf;
	logic [IDX_W-1:0]  free_idx;
	logic [IDX_W-1:0]  victim_idx;

	logic              accept;
	logic              scan_op;
	logic              out_free;
	logic [IDX_W-1:0]  target;
	logic              displaced;

	assign accept   = s_tvalid && s_tready;
	assign scan_op  = (s_tuser == OP_WRITE) || (s_tuser == OP_READ);
	assign out_free = !m_tvalid_q || m_tready;

	// A matching key wins, then the lowest free slot, then the victim.
	always_comb begin
		displaced = 1'b0;
		if (flags.hit) begin
			target = hit_idx;
		end else if (flags.free) begin
			target = free_idx;
		end else begin
			target    = victim_idx;
			displaced = 1'b1;
		end
	end

	kss_scan #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.step       (step_s1),
		.idx        (idx_s1),
		.vbit       (vbit_s1),
		.entry      (rd_s1),
		.key        (req_q.key),
		.flags      (flags),
		.hit_idx    (hit_idx),
		.hit_value  (hit_value),
		.hit_conf   (hit_conf),
		.free_idx   (free_idx),
		.victim_idx (victim_idx)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = scan_op ? ST_SCAN : ST_UPDATE;
				end
			end
			ST_SCAN: begin
				// The last compare lands in the cycle after the last read issue.
				if (step_s1 && (idx_s1 == LAST_IDX)) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= s_tuser;
			req_q.key   <= s_tdata[31:0];
			req_q.value <= s_tdata[63:32];
			req_q.conf  <= s_tdata[95:64];
			req_q.stamp <= s_tdata[127:96];
		end
	end

	// Scan address issue and the compare-stage tags that follow the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			addr_q  <= '0;
			step_s1 <= 1'b0;
		end else begin
			step_s1 <= issue_q && !accept;
			if (accept) begin
				issue_q <= scan_op;
				addr_q  <= '0;
			end else if (issue_q) begin
				if (addr_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= addr_q;
		vbit_s1 <= valid_q[addr_q];
		rd_s1   <= mem[addr_q];
	end

	// Table write port: only a write request stores an entry.
	always_ff @(posedge clk) begin
		if ((state_q == ST_UPDATE) && (op_q == OP_WRITE)) begin
			mem[target] <= req_q;
		end
	end

	// Valid bits, occupancy and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			occ_q    <= '0;
			writes_q <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			unique case (op_q)
				OP_WRITE: begin
					valid_q[target] <= 1'b1;
					writes_q        <= writes_q + 1'b1;
					if (!flags.hit && flags.free) begin
						occ_q <= occ_q + 1'b1;
					end
					if (displaced) begin
						evicts_q <= evicts_q + 1'b1;
					end
				end
				OP_READ: begin
					if (flags.hit) begin
						hits_q <= hits_q + 1'b1;
					end else begin
						misses_q <= misses_q + 1'b1;
					end
				end
				OP_CLEAR: begin
					valid_q  <= '0;
					occ_q    <= '0;
					writes_q <= '0;
					hits_q   <= '0;
					misses_q <= '0;
					evicts_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Per-request result fields.
	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			unique case (op_q)
				OP_WRITE: begin
					res_status_q <= 1'b0;
					res_value_q  <= '0;
					res_conf_q   <= '0;
					res_idx_q    <= target;
					res_evict_q  <= displaced;
				end
				OP_READ: begin
					res_status_q <= !flags.hit;
					res_value_q  <= flags.hit ? hit_value : '0;
					res_conf_q   <= flags.hit ? hit_conf : '0;
					res_idx_q    <= flags.hit ? hit_idx : '0;
					res_evict_q  <= 1'b0;
				end
				default: begin
					res_status_q <= 1'b0;
					res_value_q  <= '0;
					res_conf_q   <= '0;
					res_idx_q    <= '0;
					res_evict_q  <= 1'b0;
				end
			endcase
		end
	end

	// Output register: holds a beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= {
				5'd0,
				evicts_q,
				misses_q,
				hits_q,
				writes_q,
				ACTIVE_FIELD_W'(occ_q),
				res_evict_q,
				SLOT_FIELD_W'(res_idx_q),
				res_conf_q,
				res_value_q,
				res_status_q
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* design/kss_scan.sv */
module kss_scan #(
	parameter int SLOT_COUNT = kss_pkg::DEF_SLOT_COUNT,
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     step,
	input  logic [IDX_W-1:0]         idx,
	input  logic                     vbit,
	input  kss_pkg::entry_t          entry,
	input  logic [kss_pkg::KEY_W-1:0] key,
	output kss_pkg::scan_flags_t     flags,
	output logic [IDX_W-1:0]         hit_idx,
	output logic [kss_pkg::DATA_W-1:0] hit_value,
	output logic [kss_pkg::CONF_W-1:0] hit_conf,
	output logic [IDX_W-1:0]         free_idx,
	output logic [IDX_W-1:0]         victim_idx
);
	import kss_pkg::*;

	scan_flags_t       flags_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [DATA_W-1:0] hit_value_q;
	logic [CONF_W-1:0] hit_conf_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [IDX_W-1:0]  victim_idx_q;
	logic [CONF_W-1:0] victim_conf_q;
	logic [TIME_W-1:0] victim_time_q;
	logic              match;
	logic              lower;

	assign match = vbit && (entry.key == key);

	// Lower signed confidence wins; equal confidence falls to the older stamp.
	// A strict compare keeps the lowest index on a full tie.
	assign lower = ($signed(entry.conf) < $signed(victim_conf_q)) ||
		((entry.conf == victim_conf_q) && (entry.stamp < victim_time_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (start) begin
			flags_q <= '0;
		end else if (step) begin
			if (match && !flags_q.hit) begin
				flags_q.hit <= 1'b1;
			end
			if (!vbit && !flags_q.free) begin
				flags_q.free <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (match && !flags_q.hit) begin
				hit_idx_q   <= idx;
				hit_value_q <= entry.value;
				hit_conf_q  <= entry.conf;
			end
			if (!vbit && !flags_q.free) begin
				free_idx_q <= idx;
			end
			if ((idx == '0) || lower) begin
				victim_idx_q  <= idx;
				victim_conf_q <= entry.conf;
				victim_time_q <= entry.stamp;
			end
		end
	end

	assign flags      = flags_q;
	assign hit_idx    = hit_idx_q;
	assign hit_value  = hit_value_q;
	assign hit_conf   = hit_conf_q;
	assign free_idx   = free_idx_q;
	assign victim_idx = victim_idx_q;

endmodule
